// ----- hdl/huffman_code_bit_packer_defines.svh -----
// Assertion macros shared by the packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication.
`define HCBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hcbp_pkg.sv -----
package hcbp_pkg;

    localparam int CODE_W        = 64;
    localparam int CODE_LEN_W    = 7;
    localparam int SYM_W         = 8;
    localparam int TABLE_DEPTH   = 256;
    localparam int MAX_CODE_BITS_DEF = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [2:0] POS_INIT = 3'd7;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [SYM_W-1:0]      symbol;
        logic [CODE_W-1:0]     code_bits;
        logic [CODE_LEN_W-1:0] code_length;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } rsp_t;

endpackage

// ----- hdl/hcbp_table.sv -----
module hcbp_table
    import hcbp_pkg::*;
#(
    parameter int ENTRY_W = MAX_CODE_BITS_DEF + CODE_LEN_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [SYM_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [SYM_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    output logic               rd_hit
);

    logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries never loaded read back with rd_hit low, which the packer treats as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

// ----- hdl/huffman_code_bit_packer.sv -----
// Channel | Valid     | Stall     | Payload | Moves
// --------+-----------+-----------+---------+--------------------------------
// req     | req_valid | req_stall | req_t   | load, encode or flush request
// rsp     | rsp_valid | rsp_stall | rsp_t   | one packed byte, last flag
//
// Load writes the table entry. Flush emits the pending partial byte through the
// flush state when bits are pending. Encode reads the table, then packs one
// output byte per cycle while rsp is not stalled and keeps a trailing partial fill pending.
// Reset clears the table valid bits, pending byte and position at once.
// A stalled rsp holds the packer before it writes the next byte.
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);
    localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_PACK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [MAX_CODE_BITS-1:0] code_reg, code_next;
    logic [LEN_W-1:0]         n_reg, n_next;
    logic [7:0]               pending_reg, pending_next;
    logic [2:0]               pos_reg, pos_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    logic                     accept;
    logic [LEN_W-1:0]         len_clamp;
    logic [LEN_W-1:0]         shamt;
    logic [MAX_CODE_BITS-1:0] aligned;
    logic                     wr_en;
    logic                     rd_en;
    logic [ENTRY_W-1:0]       rd_data;
    logic                     rd_hit;
    logic [LEN_W-1:0]         rd_len;
    logic [3:0]               avail;
    logic [LEN_W-1:0]         avail_ext;
    logic [7:0]               merged;
    logic                     fills;
    logic [LEN_W-1:0]         rem;
    logic                     out_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // codes are stored left aligned; the shift drops bits above the length
    always_comb
    begin
        if (req.code_length > CODE_LEN_W'(MAX_CODE_BITS))
        begin
            len_clamp = LEN_W'(MAX_CODE_BITS);
        end
        else
        begin
            len_clamp = req.code_length[LEN_W-1:0];
        end
    end

    assign shamt   = LEN_W'(MAX_CODE_BITS) - len_clamp;
    assign aligned = req.code_bits[MAX_CODE_BITS-1:0] << shamt;
    assign wr_en   = accept && (req.opcode == OP_LOAD);
    assign rd_en   = accept && (req.opcode == OP_ENCODE);

    hcbp_table #(
        .ENTRY_W (ENTRY_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (req.symbol),
        .wr_data ({len_clamp, aligned}),
        .rd_en   (rd_en),
        .rd_addr (req.symbol),
        .rd_data (rd_data),
        .rd_hit  (rd_hit)
    );

    assign rd_len = rd_hit ? rd_data[ENTRY_W-1 -: LEN_W] : '0;

    assign avail     = {1'b0, pos_reg} + 4'd1;
    assign avail_ext = LEN_W'(avail);
    assign merged    = pending_reg | (code_reg[MAX_CODE_BITS-1 -: 8] >> (POS_INIT - pos_reg));
    assign fills     = (n_reg >= avail_ext);
    assign rem       = n_reg - avail_ext;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        n_next         = n_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_ENCODE)
                    begin
                        state_next = ST_READ;
                    end
                    else if (req.opcode == OP_FLUSH && pos_reg != POS_INIT)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_len == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    code_next  = rd_data[MAX_CODE_BITS-1:0];
                    n_next     = rd_len;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (!fills)
                begin
                    pending_next = merged;
                    pos_next     = pos_reg - n_reg[2:0];
                    n_next       = '0;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.out_byte = merged;
                    rsp_next.last     = (rem < LEN_W'(8));
                    pending_next      = '0;
                    pos_next          = POS_INIT;
                    n_next            = rem;
                    code_next         = code_reg << avail;
                    state_next        = (rem == '0) ? ST_IDLE : ST_PACK;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.out_byte = pending_reg;
                    rsp_next.last     = 1'b1;
                    pending_next      = '0;
                    pos_next          = POS_INIT;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            pending_reg   <= '0;
            pos_reg       <= POS_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `HCBP_ASSERT_NEXT(a_encode_reads, accept && req.opcode == OP_ENCODE, state_reg == ST_READ, "encode request did not start a table read")
    `HCBP_ASSERT_NOW(a_pack_nonempty, state_reg == ST_PACK, n_reg != '0, "packing with no bits left")
    `HCBP_ASSERT_NEXT(a_fill_emits, state_reg == ST_PACK && fills && out_free, rsp_valid_reg && pos_reg == POS_INIT && pending_reg == '0, "filled byte not emitted")
    `HCBP_ASSERT_NEXT(a_flush_clears, state_reg == ST_FLUSH && out_free, rsp_valid_reg && rsp_reg.last && pos_reg == POS_INIT, "flush left bits pending")

endmodule

// ----- sim/tb_huffman_code_bit_packer.sv -----
module tb_huffman_code_bit_packer;
    import hcbp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_GAP = 4;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // packer model
    logic [CODE_W-1:0]     code_table [TABLE_DEPTH];
    logic [CODE_LEN_W-1:0] length_table [TABLE_DEPTH];
    logic [7:0]            partial_byte;
    logic [2:0]            fill_pos;
    rsp_t                  expected_bytes [$];

    int   mismatch_count = 0;
    int   requests_sent = 0;
    int   bytes_checked = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   long_hold_req = 1'b0;
    bit   sender_idle_on = 1'b0;
    bit   receiver_idle_on = 1'b0;
    rsp_t oldest;

    huffman_code_bit_packer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void predict_request(input req_t r);
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_W-1:0]     code;
        logic [7:0]            bytes [$];
        rsp_t                  e;
        int                    n;
        case (r.opcode)
            OP_LOAD:
            begin
                len = (r.code_length > MAX_CODE_BITS_DEF) ?
                      CODE_LEN_W'(MAX_CODE_BITS_DEF) : r.code_length;
                length_table[r.symbol] = len;
                code_table[r.symbol] = (len >= CODE_W) ? r.code_bits :
                                       r.code_bits & ((64'd1 << len) - 64'd1);
            end
            OP_ENCODE:
            begin
                code = code_table[r.symbol];
                n = int'(length_table[r.symbol]);
                while (n > 0)
                begin
                    n--;
                    partial_byte[fill_pos] = code[n];
                    if (fill_pos != 3'd0)
                        fill_pos--;
                    else
                    begin
                        bytes.push_back(partial_byte);
                        partial_byte = 8'd0;
                        fill_pos = POS_INIT;
                    end
                end
            end
            OP_FLUSH:
            begin
                if (fill_pos != POS_INIT)
                begin
                    bytes.push_back(partial_byte);
                    partial_byte = 8'd0;
                    fill_pos = POS_INIT;
                end
            end
            default: ;
        endcase
        foreach (bytes[i])
        begin
            e.out_byte = bytes[i];
            e.last = (i == bytes.size() - 1);
            expected_bytes.push_back(e);
        end
    endfunction

    function automatic req_t make_request(input logic [1:0] op, input logic [7:0] sym,
                                          input logic [63:0] bits, input logic [6:0] len);
        req_t r;
        r.opcode = op;
        r.symbol = sym;
        r.code_bits = bits;
        r.code_length = len;
        return r;
    endfunction

    function automatic logic [63:0] random_code();
        return {$urandom(), $urandom()};
    endfunction

    // mostly short codes, some long, some clipped, some absent
    function automatic logic [6:0] random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 7'($urandom_range(1, 12));
        else if (pick < 85)
            return 7'($urandom_range(13, 64));
        else if (pick < 90)
            return 7'($urandom_range(65, 127));
        else
            return 7'd0;
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_directed_cases();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        send_request(make_request(OP_LOAD, 8'd0, random_code(), 7'd0));
        send_request(make_request(OP_LOAD, 8'd255, '1, 7'd64));
        send_request(make_request(OP_LOAD, 8'd1, 64'd1, 7'd1));
        send_request(make_request(OP_LOAD, 8'd3, '1, 7'd3));
        send_request(make_request(OP_LOAD, 8'd2, random_code(), 7'd127));
        send_request(make_request(OP_LOAD, 8'd4, 64'd0, 7'd64));
        send_request(make_request(OP_ENCODE, 8'd0, '1, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd255, 64'd0, 7'd0));
        send_request(make_request(OP_FLUSH, 8'd0, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd1, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd3, 64'd0, 7'd0));
        send_request(make_request(OP_FLUSH, 8'd0, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd1, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd2, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd4, 64'd0, 7'd0));
        send_request(make_request(OP_FLUSH, 8'd255, '1, 7'd127));
        send_request(make_request(OP_UNUSED, 8'd255, '1, 7'd127));
        send_request(make_request(OP_ENCODE, 8'd200, 64'd0, 7'd0));
        send_request(make_request(OP_ENCODE, 8'd3, 64'd0, 7'd0));
        send_request(make_request(OP_FLUSH, 8'd0, 64'd0, 7'd0));
        wait_for_drain();
    endtask

    // receiver holds off while long codes pile up behind it
    task automatic test_output_backpressure();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        for (int s = 0; s < 8; s++)
            send_request(make_request(OP_LOAD, 8'(8'hF0 + s), random_code(),
                                      7'($urandom_range(40, 64))));
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(make_request(OP_ENCODE, 8'(8'hF0 + $urandom_range(0, 7)),
                                      random_code(), random_length()));
        send_request(make_request(OP_FLUSH, 8'd0, 64'd0, 7'd0));
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        logic [7:0] alphabet [$];
        logic [7:0] sym;
        int         pick;
        int         sent;
        for (int i = 0; i < 48; i++)
        begin
            sym = 8'($urandom_range(0, 255));
            alphabet.push_back(sym);
            send_request(make_request(OP_LOAD, sym, random_code(), random_length()));
        end
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            sender_idle_on = (chunk == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            receiver_idle_on = (chunk == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            sent = 0;
            while (sent < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                begin
                    sym = ($urandom_range(0, 9) != 0) ?
                          alphabet[$urandom_range(0, alphabet.size() - 1)] :
                          8'($urandom_range(0, 255));
                    send_request(make_request(OP_ENCODE, sym, random_code(),
                                              random_length()));
                    sent++;
                end
                else if (pick < 88)
                begin
                    send_request(make_request(OP_FLUSH, 8'($urandom_range(0, 255)),
                                              random_code(), random_length()));
                    sent++;
                end
                else if (pick < 96)
                begin
                    sym = 8'($urandom_range(0, 255));
                    alphabet.push_back(sym);
                    send_request(make_request(OP_LOAD, sym, random_code(),
                                              random_length()));
                    sent++;
                end
                else
                    send_request(make_request(OP_UNUSED, 8'($urandom_range(0, 255)),
                                              random_code(), random_length()));
            end
            wait_for_drain();
        end
    endtask

    // receiver: per-byte gaps plus the requested long hold
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            bytes_checked++;
            gap_left = receiver_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected byte, expected none, actual out_byte %h last %b",
                         $time, rsp.out_byte, rsp.last);
            end
            else
            begin
                oldest = expected_bytes.pop_front();
                if (rsp.out_byte !== oldest.out_byte)
                begin
                    mismatch_count++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, oldest.out_byte, rsp.out_byte);
                end
                if (rsp.last !== oldest.last)
                begin
                    mismatch_count++;
                    $display("%0t: last expected %b actual %b",
                             $time, oldest.last, rsp.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            length_table[i] = '0;
        partial_byte = 8'd0;
        fill_pos = POS_INIT;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_traffic();
        wait_for_drain();

        $display("Sent %0d requests and checked %0d packed bytes", requests_sent,
                 bytes_checked);
        $display("Covered absent, clipped and 64-bit codes, flushes, ignored opcodes, ",
                 "long output hold-off and random idling on both sides");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
